// File: src/sle_pkg.sv
// Shared types and constants for the sequential list engine.
// Request and response transaction structs, action and status codes, cell commands.
// No dependencies.
package sle_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int WORD_BITS_DEF = 32;

    localparam logic [2:0] ACT_READ   = 3'd0;
    localparam logic [2:0] ACT_WRITE  = 3'd1;
    localparam logic [2:0] ACT_INSERT = 3'd2;
    localparam logic [2:0] ACT_REMOVE = 3'd3;
    localparam logic [2:0] ACT_SEARCH = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_POS   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [6:0]  position;
        logic [31:0] value;
    } sle_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic [5:0]  found_position;
        logic [6:0]  length_now;
    } sle_rsp_t;

    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_READ,
        CELL_WRITE,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_SEARCH
    } cell_op_t;

    typedef struct packed {
        logic     en;
        cell_op_t op;
    } sle_cell_cmd_t;

endpackage

// File: src/sle_cell.sv
// One list entry: holds a word, shifts with its neighbors, answers read and search.
// Depends on sle_pkg.
module sle_cell #(
    parameter int INDEX     = 0,
    parameter int WORD_BITS = 32,
    parameter int POS_BITS  = 7
) (
    input  logic                  clk,
    input  sle_pkg::sle_cell_cmd_t cmd,
    input  logic [POS_BITS-1:0]   pos,
    input  logic [POS_BITS-1:0]   count,
    input  logic [WORD_BITS-1:0]  value,
    input  logic [WORD_BITS-1:0]  prev_data,
    input  logic [WORD_BITS-1:0]  next_data,
    output logic [WORD_BITS-1:0]  data,
    output logic [WORD_BITS-1:0]  rd_data,
    output logic                  hit
);
    import sle_pkg::*;

    localparam logic [POS_BITS-1:0] IDX = POS_BITS'(INDEX);

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;
    logic [WORD_BITS-1:0] rd_reg;
    logic [WORD_BITS-1:0] rd_next;
    logic                 hit_reg;
    logic                 hit_next;

    always_comb
    begin
        data_next = data_reg;
        rd_next   = '0;
        hit_next  = 1'b0;
        case (cmd.op)
            CELL_READ:
            begin
                if (IDX == pos)
                begin
                    rd_next = data_reg;
                end
            end
            CELL_WRITE:
            begin
                if (IDX == pos)
                begin
                    data_next = value;
                end
            end
            CELL_INSERT:
            begin
                if (IDX == pos)
                begin
                    data_next = value;
                end
                else if (IDX > pos)
                begin
                    data_next = prev_data;
                end
            end
            CELL_REMOVE:
            begin
                if (IDX >= pos)
                begin
                    data_next = next_data;
                end
            end
            CELL_SEARCH:
            begin
                hit_next = (IDX < count) && (data_reg == value);
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.en)
        begin
            data_reg <= data_next;
            rd_reg   <= rd_next;
            hit_reg  <= hit_next;
        end
    end

    assign data    = data_reg;
    assign rd_data = rd_reg;
    assign hit     = hit_reg;

endmodule

// File: src/sle_reduce.sv
// Two-level registered reduction over the cell row: read data OR and lowest hit.
// Depends on sle_pkg.
module sle_reduce #(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                        clk,
    input  logic [WORD_BITS-1:0]        rd_data [CAPACITY],
    input  logic                        hit [CAPACITY],
    output logic [WORD_BITS-1:0]        data,
    output logic                        found_any,
    output logic [$clog2(CAPACITY)-1:0] found_index
);
    import sle_pkg::*;

    localparam int GROUP = 8;
    localparam int NG    = (CAPACITY + GROUP - 1) / GROUP;
    localparam int IW    = $clog2(CAPACITY);

    logic [WORD_BITS-1:0] l1_data_reg [NG];
    logic [WORD_BITS-1:0] l1_data_next [NG];
    logic                 l1_any_reg [NG];
    logic                 l1_any_next [NG];
    logic [2:0]           l1_low_reg [NG];
    logic [2:0]           l1_low_next [NG];

    logic [WORD_BITS-1:0] l2_data_reg;
    logic [WORD_BITS-1:0] l2_data_next;
    logic                 l2_any_reg;
    logic                 l2_any_next;
    logic [IW-1:0]        l2_idx_reg;
    logic [IW-1:0]        l2_idx_next;

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            l1_data_next[g] = '0;
            l1_any_next[g]  = 1'b0;
            l1_low_next[g]  = '0;
            for (int j = GROUP - 1; j >= 0; j--)
            begin
                if (g * GROUP + j < CAPACITY)
                begin
                    l1_data_next[g] = l1_data_next[g] | rd_data[g * GROUP + j];
                    if (hit[g * GROUP + j])
                    begin
                        l1_any_next[g] = 1'b1;
                        l1_low_next[g] = 3'(j);
                    end
                end
            end
        end
    end

    always_comb
    begin
        l2_data_next = '0;
        l2_any_next  = 1'b0;
        l2_idx_next  = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            l2_data_next = l2_data_next | l1_data_reg[g];
            if (l1_any_reg[g])
            begin
                l2_any_next = 1'b1;
                l2_idx_next = IW'(g * GROUP + int'(l1_low_reg[g]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        l1_data_reg <= l1_data_next;
        l1_any_reg  <= l1_any_next;
        l1_low_reg  <= l1_low_next;
        l2_data_reg <= l2_data_next;
        l2_any_reg  <= l2_any_next;
        l2_idx_reg  <= l2_idx_next;
    end

    assign data        = l2_data_reg;
    assign found_any   = l2_any_reg;
    assign found_index = l2_idx_reg;

endmodule

// File: src/sequential_list_engine.sv
// Top level of the sequential list engine: control, entry count, cell row, reduction.
// Depends on sle_pkg, sle_cell and sle_reduce.

// Ordered list of up to CAPACITY words held in a row of cells, one entry per
// cell. Every request transaction (read, write, insert, remove, search) goes
// from acceptance through an execute state in which all cells shift, write or
// compare at once, then the two registered levels of the read/search reduction
// tree, then a done state that loads the response register when no response is
// pending or the response side is not stalling. A new request can be taken in the
// cycle after the previous one has reached the response register, so requests
// never overlap. Entries not yet written hold unknown data; reset only empties
// the list.
module sequential_list_engine #(
    parameter int CAPACITY  = sle_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = sle_pkg::WORD_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  sle_pkg::sle_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output sle_pkg::sle_rsp_t rsp
);
    import sle_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 7) ? CW : 7;
    localparam int IW = $clog2(CAPACITY);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_RED_A = 5'b00100,
        S_RED_B = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    sle_req_t       req_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [1:0]     status_reg;
    logic [1:0]     status_next;
    logic           rsp_valid_reg;
    logic           rsp_valid_next;
    sle_rsp_t       rsp_reg;
    sle_rsp_t       rsp_next;

    sle_cell_cmd_t  cell_cmd;
    logic [XW-1:0]  pos_x;
    logic [XW-1:0]  count_x;
    logic [WORD_BITS-1:0] value_w;

    logic [WORD_BITS-1:0] cell_data [CAPACITY];
    logic [WORD_BITS-1:0] cell_rd [CAPACITY];
    logic                 cell_hit [CAPACITY];

    logic [WORD_BITS-1:0] tree_data;
    logic                 tree_any;
    logic [IW-1:0]        tree_idx;

    logic req_take;
    logic rsp_load;

    assign pos_x    = XW'(req_reg.position);
    assign count_x  = XW'(count_reg);
    assign value_w  = WORD_BITS'(req_reg.value);
    assign req_take = req_valid && !req_stall;
    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        cell_cmd.en  = (state_reg == S_EXEC);
        cell_cmd.op  = CELL_NOP;
        count_next   = count_reg;
        status_next  = status_reg;
        if (state_reg == S_EXEC)
        begin
            status_next = ST_OK;
            case (req_reg.action)
                ACT_READ:
                begin
                    if (pos_x < count_x)
                        cell_cmd.op = CELL_READ;
                    else
                        status_next = ST_BAD_POS;
                end
                ACT_WRITE:
                begin
                    if (pos_x < count_x)
                        cell_cmd.op = CELL_WRITE;
                    else
                        status_next = ST_BAD_POS;
                end
                ACT_INSERT:
                begin
                    if (count_x == XW'(CAPACITY))
                        status_next = ST_FULL;
                    else if (pos_x > count_x)
                        status_next = ST_BAD_POS;
                    else
                    begin
                        cell_cmd.op = CELL_INSERT;
                        count_next  = CW'(count_reg + 1'b1);
                    end
                end
                ACT_REMOVE:
                begin
                    if (pos_x < count_x)
                    begin
                        cell_cmd.op = CELL_REMOVE;
                        count_next  = CW'(count_reg - 1'b1);
                    end
                    else
                        status_next = ST_BAD_POS;
                end
                ACT_SEARCH:
                begin
                    cell_cmd.op = CELL_SEARCH;
                end
                default:
                begin
                    cell_cmd.op = CELL_NOP;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (req_take) state_next = S_EXEC;
            S_EXEC:  state_next = S_RED_A;
            S_RED_A: state_next = S_RED_B;
            S_RED_B: state_next = S_DONE;
            S_DONE:  if (rsp_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_next                = rsp_reg;
        rsp_valid_next          = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        if (rsp_load)
        begin
            rsp_valid_next          = 1'b1;
            rsp_next.status         = status_reg;
            rsp_next.read_value     = 32'(tree_data);
            rsp_next.found_position = '0;
            rsp_next.length_now     = 7'(count_reg);
            if (req_reg.action == ACT_SEARCH)
            begin
                if (tree_any)
                begin
                    rsp_next.status         = ST_OK;
                    rsp_next.found_position = 6'(tree_idx);
                end
                else
                    rsp_next.status = ST_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
            req_reg <= req;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [WORD_BITS-1:0] prev_w;
            logic [WORD_BITS-1:0] next_w;
            if (i == 0)
            begin : g_first
                assign prev_w = '0;
            end
            else
            begin : g_mid
                assign prev_w = cell_data[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign next_w = '0;
            end
            else
            begin : g_inner
                assign next_w = cell_data[i+1];
            end

            sle_cell #(
                .INDEX     (i),
                .WORD_BITS (WORD_BITS),
                .POS_BITS  (XW)
            ) u_cell (
                .clk       (clk),
                .cmd       (cell_cmd),
                .pos       (pos_x),
                .count     (count_x),
                .value     (value_w),
                .prev_data (prev_w),
                .next_data (next_w),
                .data      (cell_data[i]),
                .rd_data   (cell_rd[i]),
                .hit       (cell_hit[i])
            );
        end
    endgenerate

    sle_reduce #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_reduce (
        .clk         (clk),
        .rd_data     (cell_rd),
        .hit         (cell_hit),
        .data        (tree_data),
        .found_any   (tree_any),
        .found_index (tree_idx)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_take_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> state_reg == S_EXEC)
        else $error("accepted transaction not executed");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_EXEC |=> $stable(count_reg))
        else $error("entry count changed outside execute");

    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("response raised without a finished transaction");
`endif

endmodule
